>>> hdl/pixel_replicate_upscaler_assert.svh
// ----------------------------------------------------------------------------
// Pixel replicate upscaler assertion macros
// Shared concurrent assertion forms used by the upscaler modules.
// ----------------------------------------------------------------------------
`ifndef PIXEL_REPLICATE_UPSCALER_ASSERT_SVH
`define PIXEL_REPLICATE_UPSCALER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PRU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// Next-cycle implication, disabled during reset.
`define PRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

>>> hdl/pru_pkg.sv
// ----------------------------------------------------------------------------
// Pixel replicate upscaler package
// Shared types, codes and sizing constants.
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;

   // comparison width for widths and row counters (holds 8192 + 1)
   localparam int CMP_W = 14;

   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd2;

   localparam logic [6:0]  MAX_FACTOR = 7'd100;
   localparam logic [12:0] MAX_HEIGHT = 13'd4096;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
   localparam logic [1:0] STATUS_PIXEL     = 2'd1;
   localparam logic [1:0] STATUS_NOT_READY = 2'd2;
   localparam logic [1:0] STATUS_REFUSED   = 2'd3;

   // output queue sizing
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = 2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [1:0] status;
      logic       line_end;
      logic [1:0] pad_bytes;
      logic       image_end;
   } rsp_meta_type;

   typedef struct packed {
      rsp_meta_type meta;
      pixel_type    pixel;
   } outq_entry_type;

   typedef struct packed {
      logic      wr_en;
      logic      rd_en;
      pixel_type wdata;
   } mem_cmd_type;

endpackage

>>> hdl/pru_row_mem.sv
// ----------------------------------------------------------------------------
// Row buffer memory
// One source row of pixels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pru_row_mem
   import pru_pkg::*;
#(
   parameter int  MAX_WIDTH = DEFAULT_MAX_WIDTH,
   localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic              clock,
   input  mem_cmd_type       mem_cmd,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [ADDR_W-1:0] raddr,
   output pixel_type         rdata
);

   pixel_type mem_ff [MAX_WIDTH];
   pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[waddr] <= mem_cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/pru_ctrl.sv
// ----------------------------------------------------------------------------
// Upscaler control
// Configuration registers, fill and replicate counters, result metadata stage.
// ----------------------------------------------------------------------------
`include "pixel_replicate_upscaler_assert.svh"

module pru_ctrl
   import pru_pkg::*;
#(
   parameter int  MAX_WIDTH = DEFAULT_MAX_WIDTH,
   localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_fire,
   input  logic                  req_type,
   input  pixel_type             req_pixel,
   output mem_cmd_type           mem_cmd,
   output logic [ADDR_W-1:0]     mem_waddr,
   output logic [ADDR_W-1:0]     mem_raddr,
   output logic                  s1_valid,
   output rsp_meta_type          s1_meta
);

   logic [6:0]  scale_ff, scale_in;
   logic [10:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic              row_ready_ff, row_ready_in;
   logic [6:0]        horiz_ff, horiz_in;
   logic [6:0]        vert_ff, vert_in;
   logic [11:0]       src_row_ff, src_row_in;

   logic         s1_valid_ff;
   rsp_meta_type s1_meta_ff, s1_meta_in;

   logic [6:0]       f_eff;
   logic [CMP_W-1:0] w_eff;
   logic [12:0]      h_eff;
   logic [3:0]       pad_prod;
   logic             last_fill, last_h, last_px, last_v, last_row;

   // config write
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SCALE_FACTOR:  scale_in  = csr_wdata[6:0];
            CSR_SOURCE_WIDTH:  width_in  = csr_wdata[10:0];
            CSR_SOURCE_HEIGHT: height_in = csr_wdata[12:0];
            default:           ;
         endcase
      end
   end

   // clamp registers to their working ranges
   always_comb begin
      if (scale_ff == 7'd0) begin
         f_eff = 7'd1;
      end else if (scale_ff > MAX_FACTOR) begin
         f_eff = MAX_FACTOR;
      end else begin
         f_eff = scale_ff;
      end

      if (width_ff == 11'd0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end

      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
   end

   // line padding: (4 - 3*w*f mod 4) mod 4 reduces to w*f mod 4
   assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, f_eff[1:0]};

   assign last_fill = (CMP_W'(fill_ff) + CMP_W'(1)) >= w_eff;
   assign last_px   = (CMP_W'(rd_idx_ff) + CMP_W'(1)) >= w_eff;
   assign last_h    = ({1'b0, horiz_ff} + 8'd1) >= {1'b0, f_eff};
   assign last_v    = ({1'b0, vert_ff} + 8'd1) >= {1'b0, f_eff};
   assign last_row  = ({1'b0, src_row_ff} + 13'd1) >= h_eff;

   always_comb begin
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      row_ready_in = row_ready_ff;
      horiz_in     = horiz_ff;
      vert_in      = vert_ff;
      src_row_in   = src_row_ff;
      s1_meta_in   = '0;
      mem_cmd      = '0;
      mem_cmd.wdata = req_pixel;

      if (req_fire) begin
         if (req_type == REQ_PUSH) begin
            if (row_ready_ff) begin
               s1_meta_in.status = STATUS_REFUSED;
            end else begin
               mem_cmd.wr_en     = 1'b1;
               s1_meta_in.status = STATUS_ACCEPTED;
               if (last_fill) begin
                  fill_in      = '0;
                  row_ready_in = 1'b1;
                  rd_idx_in    = '0;
                  horiz_in     = '0;
                  vert_in      = '0;
               end else begin
                  fill_in = fill_ff + ADDR_W'(1);
               end
            end
         end else if (!row_ready_ff) begin
            s1_meta_in.status = STATUS_NOT_READY;
         end else begin
            mem_cmd.rd_en        = 1'b1;
            s1_meta_in.status    = STATUS_PIXEL;
            s1_meta_in.line_end  = last_h && last_px;
            s1_meta_in.pad_bytes = (last_h && last_px) ? pad_prod[1:0] : 2'd0;
            s1_meta_in.image_end = last_h && last_px && last_v && last_row;
            // advance horizontal repeat, then pixel, then vertical repeat
            if (!last_h) begin
               horiz_in = horiz_ff + 7'd1;
            end else begin
               horiz_in = '0;
               if (!last_px) begin
                  rd_idx_in = rd_idx_ff + ADDR_W'(1);
               end else begin
                  rd_idx_in = '0;
                  if (!last_v) begin
                     vert_in = vert_ff + 7'd1;
                  end else begin
                     vert_in      = '0;
                     row_ready_in = 1'b0;
                     src_row_in   = last_row ? 12'd0 : src_row_ff + 12'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= 7'd1;
         width_ff     <= 11'd1;
         height_ff    <= 13'd1;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         row_ready_ff <= 1'b0;
         horiz_ff     <= '0;
         vert_ff      <= '0;
         src_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         row_ready_ff <= row_ready_in;
         horiz_ff     <= horiz_in;
         vert_ff      <= vert_in;
         src_row_ff   <= src_row_in;
         s1_valid_ff  <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meta_ff <= s1_meta_in;
      end
   end

   assign mem_waddr = fill_ff;
   assign mem_raddr = rd_idx_ff;
   assign s1_valid  = s1_valid_ff;
   assign s1_meta   = s1_meta_ff;

   `PRU_ASSERT_NEXT(a_push_refused, clock, reset, req_fire && req_type == REQ_PUSH && row_ready_ff, s1_valid_ff && s1_meta_ff.status == STATUS_REFUSED)
   `PRU_ASSERT_SAME(a_fill_idle_when_ready, clock, reset, row_ready_ff, fill_ff == '0)
   `PRU_ASSERT_SAME(a_image_end_on_line_end, clock, reset, s1_valid_ff && s1_meta_ff.image_end, s1_meta_ff.line_end && s1_meta_ff.status == STATUS_PIXEL)

endmodule

>>> hdl/pru_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Three-entry queue that holds finished results until the consumer takes them.
// ----------------------------------------------------------------------------
`include "pixel_replicate_upscaler_assert.svh"

module pru_out_fifo
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  outq_entry_type        push_entry,
   input  logic                  pop,
   output outq_entry_type        head,
   output logic [OUTQ_PTR_W-1:0] count
);

   localparam logic [OUTQ_PTR_W-1:0] LAST_PTR = OUTQ_PTR_W'(OUTQ_DEPTH - 1);
   localparam logic [OUTQ_PTR_W-1:0] FULL_CNT = OUTQ_PTR_W'(OUTQ_DEPTH);

   outq_entry_type        entries_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_PTR_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + OUTQ_PTR_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUTQ_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign count = count_ff;

   `PRU_ASSERT_SAME(a_no_overflow, clock, reset, push && count_ff == FULL_CNT, pop)
   `PRU_ASSERT_SAME(a_empty_ptrs_match, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)
   `PRU_ASSERT_NEXT(a_head_holds, clock, reset, !pop && count_ff != '0, $stable(head))

endmodule

>>> hdl/pixel_replicate_upscaler.sv
// ----------------------------------------------------------------------------
// Pixel replicate upscaler
// Integer nearest-neighbor upscaler for 24-bit BGR rasters with a row buffer.
// ----------------------------------------------------------------------------
// One request transfer per clock is taken while req_ready is high, pushes and
// ticks mixed freely, and every request yields exactly one response transfer.
// This sustained rate is set by the row buffer memory, which has one write
// port (pushes) and one registered read port (ticks); the counters and end
// tests settle in the same cycle. req_ready depends only on registered
// occupancy: it drops when the three-entry response queue plus the in-flight
// stage would be full, so a stalled consumer costs throughput only once the
// queue has filled. Pushes fill the row buffer; once source_width pixels are
// in, ticks emit each pixel scale_factor times and the row scale_factor
// times, marking line ends with the pad byte count and the last pixel of the
// image. Pushes during emission are refused, ticks with no row held answer
// not ready. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [7:0]            req_in_blue,
   input  logic [7:0]            req_in_green,
   input  logic [7:0]            req_in_red,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_out_blue,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_red,
   output logic                  rsp_line_end,
   output logic [1:0]            rsp_pad_bytes,
   output logic                  rsp_image_end
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic                  req_fire;
   pixel_type             req_pixel;
   mem_cmd_type           mem_cmd;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [ADDR_W-1:0]     mem_raddr;
   pixel_type             mem_rdata;
   logic                  s1_valid;
   rsp_meta_type          s1_meta;
   outq_entry_type        s1_entry;
   outq_entry_type        outq_head;
   logic [OUTQ_PTR_W-1:0] outq_count;
   logic [OUTQ_PTR_W:0]   occupancy;
   logic                  rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   assign req_pixel.blue  = req_in_blue;
   assign req_pixel.green = req_in_green;
   assign req_pixel.red   = req_in_red;

   // hold off requests while the in-flight stage plus the queue could overflow
   assign occupancy = {1'b0, outq_count} + {{OUTQ_PTR_W{1'b0}}, s1_valid};
   assign req_ready = occupancy < (OUTQ_PTR_W + 1)'(OUTQ_DEPTH);

   pru_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_fire     (req_fire),
      .req_type     (req_type),
      .req_pixel    (req_pixel),
      .mem_cmd      (mem_cmd),
      .mem_waddr    (mem_waddr),
      .mem_raddr    (mem_raddr),
      .s1_valid     (s1_valid),
      .s1_meta      (s1_meta)
   );

   pru_row_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_row_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .waddr   (mem_waddr),
      .raddr   (mem_raddr),
      .rdata   (mem_rdata)
   );

   // drop stale read data on results that carry no pixel
   assign s1_entry.meta  = s1_meta;
   assign s1_entry.pixel = (s1_meta.status == STATUS_PIXEL) ? mem_rdata : '0;

   pru_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid),
      .push_entry (s1_entry),
      .pop        (rsp_fire),
      .head       (outq_head),
      .count      (outq_count)
   );

   assign rsp_valid     = outq_count != '0;
   assign rsp_status    = outq_head.meta.status;
   assign rsp_out_blue  = outq_head.pixel.blue;
   assign rsp_out_green = outq_head.pixel.green;
   assign rsp_out_red   = outq_head.pixel.red;
   assign rsp_line_end  = outq_head.meta.line_end;
   assign rsp_pad_bytes = outq_head.meta.pad_bytes;
   assign rsp_image_end = outq_head.meta.image_end;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Pixel replicate upscaler testbench
// Drives pushes and output ticks through the request channel and checks every
// response against a cycle-free predictor of the upscaler. A short table of
// directed steps covers the register extremes and the refuse and not-ready
// answers; random phases follow with new register settings, random
// back-pressure on both sides, one long response stall and one mid-phase drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import pru_pkg::*;

   localparam int MAX_W           = DEFAULT_MAX_WIDTH;
   localparam int ROW_IDX_W       = (MAX_W > 1) ? $clog2(MAX_W) : 1;
   localparam int RANDOM_ITEMS    = 1050;
   localparam int SETTLE_CYCLES   = 6;      // the response is registered in the in-flight stage, then in the queue
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int HOLD_PHASE      = 2;
   localparam int PAUSE_PHASE     = 4;
   localparam int CYCLE_LIMIT     = 400000;

   // index 3 is decoded by no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      pixel_type  pixel;
      logic       line_end;
      logic [1:0] pad_bytes;
      logic       image_end;
   } scaled_output_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic                  kind;
      pixel_type             px;
      logic                  typed;
      scaled_output_type     want;
   } directed_step_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [7:0]            req_in_blue;
   logic [7:0]            req_in_green;
   logic [7:0]            req_in_red;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_status;
   logic [7:0]            rsp_out_blue;
   logic [7:0]            rsp_out_green;
   logic [7:0]            rsp_out_red;
   logic                  rsp_line_end;
   logic [1:0]            rsp_pad_bytes;
   logic                  rsp_image_end;

   // predictor copy of the registers and the row buffer state
   logic [6:0]  factor_reg = 7'd1;
   logic [10:0] width_reg  = 11'd1;
   logic [12:0] height_reg = 13'd1;
   pixel_type   row_store [MAX_W];
   bit          row_written [MAX_W];
   int unsigned fill_count   = 0;
   bit          row_held     = 1'b0;
   int unsigned read_index   = 0;
   int unsigned horiz_repeat = 0;
   int unsigned vert_repeat  = 0;
   int unsigned source_row   = 0;

   scaled_output_type scaled_outputs_due [$];

   bit tx_idle_on       = 1'b1;
   bit rx_idle_on       = 1'b1;
   bit hold_off_request = 1'b0;

   int cycle_count       = 0;
   int mismatch_count    = 0;
   int responses_checked = 0;
   int csr_writes        = 0;
   int status_count [4]  = '{0, 0, 0, 0};
   int line_end_count    = 0;
   int image_end_count   = 0;

   pixel_replicate_upscaler i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_in_blue   (req_in_blue),
      .req_in_green  (req_in_green),
      .req_in_red    (req_in_red),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_green (rsp_out_green),
      .rsp_out_red   (rsp_out_red),
      .rsp_line_end  (rsp_line_end),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_image_end (rsp_image_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses still due",
               cycle_count, scaled_outputs_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Clamp the width register the way the block reads it.
   function automatic int unsigned effective_width(logic [10:0] value);
      if (value == 11'd0) return 1;
      if (32'(value) > MAX_W) return MAX_W;
      return 32'(value);
   endfunction

   // Advance the predictor by one accepted request and return its response.
   function automatic scaled_output_type scale_pixel_step(logic kind, pixel_type px);
      scaled_output_type res;
      int unsigned       w, f, h, pad;
      bit                last_h, last_px, last_v, last_row;
      res = '0;
      w   = effective_width(width_reg);
      if (factor_reg == 7'd0) f = 1;
      else if (factor_reg > MAX_FACTOR) f = 32'(MAX_FACTOR);
      else f = 32'(factor_reg);
      if (height_reg == 13'd0) h = 1;
      else if (height_reg > MAX_HEIGHT) h = 32'(MAX_HEIGHT);
      else h = 32'(height_reg);
      if (kind == REQ_PUSH) begin
         if (row_held) begin
            res.status = STATUS_REFUSED;
         end else begin
            row_store[ROW_IDX_W'(fill_count % MAX_W)]   = px;
            row_written[ROW_IDX_W'(fill_count % MAX_W)] = 1'b1;
            if (fill_count + 1 >= w) begin
               fill_count   = 0;
               row_held     = 1'b1;
               read_index   = 0;
               horiz_repeat = 0;
               vert_repeat  = 0;
            end else begin
               fill_count++;
            end
            res.status = STATUS_ACCEPTED;
         end
      end else if (!row_held) begin
         res.status = STATUS_NOT_READY;
      end else begin
         last_h   = horiz_repeat + 1 >= f;
         last_px  = read_index + 1 >= w;
         last_v   = vert_repeat + 1 >= f;
         last_row = source_row + 1 >= h;
         pad      = (4 - ((3 * w * f) & 3)) & 3;
         res.status    = STATUS_PIXEL;
         res.pixel     = row_store[ROW_IDX_W'(read_index % MAX_W)];
         res.line_end  = last_h && last_px;
         res.pad_bytes = (last_h && last_px) ? pad[1:0] : 2'd0;
         res.image_end = last_h && last_px && last_v && last_row;
         if (!last_h) begin
            horiz_repeat++;
         end else begin
            horiz_repeat = 0;
            if (!last_px) begin
               read_index++;
            end else begin
               read_index = 0;
               if (!last_v) begin
                  vert_repeat++;
               end else begin
                  vert_repeat = 0;
                  row_held    = 1'b0;
                  source_row  = last_row ? 0 : source_row + 1;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic directed_step_type csr_step(logic [CSR_IDX_W-1:0] idx,
                                                  logic [CSR_DATA_W-1:0] data);
      directed_step_type s;
      s         = '0;
      s.is_csr  = 1'b1;
      s.csr_idx = idx;
      s.csr_data = data;
      return s;
   endfunction

   function automatic directed_step_type item_step(logic kind, pixel_type px);
      directed_step_type s;
      s      = '0;
      s.kind = kind;
      s.px   = px;
      return s;
   endfunction

   function automatic directed_step_type typed_step(logic kind, pixel_type px,
                                                    logic [1:0] status, pixel_type opx,
                                                    logic le, logic [1:0] pad, logic ie);
      directed_step_type s;
      s                = item_step(kind, px);
      s.typed          = 1'b1;
      s.want.status    = status;
      s.want.pixel     = opx;
      s.want.line_end  = le;
      s.want.pad_bytes = pad;
      s.want.image_end = ie;
      return s;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("[cycle %0d] response %0d %s: got %0d, expected %0d",
               cycle_count, responses_checked, field, got, want);
      mismatch_count++;
   endtask

   // Write one register on an idle block; starts and ends at a falling edge.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_SCALE_FACTOR:  factor_reg = data[6:0];
         CSR_SOURCE_WIDTH:  width_reg  = data[10:0];
         CSR_SOURCE_HEIGHT: height_reg = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Offer one request, hold it until the transfer, then log what it owes.
   task automatic send_item(logic kind, pixel_type px, bit typed, scaled_output_type want);
      int                gap;
      scaled_output_type pred;
      gap = tx_idle_on ? int'($urandom_range(0, 13)) : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_type     = kind;
      req_in_blue  = px.blue;
      req_in_green = px.green;
      req_in_red   = px.red;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = scale_pixel_step(kind, px);
      if (typed) pred = want;
      scaled_outputs_due.push_back(pred);
      status_count[pred.status]++;
      line_end_count  += int'(pred.line_end);
      image_end_count += int'(pred.image_end);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed response has been taken.
   task automatic drain(int settle);
      req_valid = 1'b0;
      while (scaled_outputs_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: stall at random, check each transfer against the oldest
   // owed response. A hold-off request freezes ready for a long stretch.
   initial begin
      int                stall;
      scaled_output_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            stall = rx_idle_on ? int'($urandom_range(0, 13)) : 0;
            if (stall != 0) begin
               rsp_ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (scaled_outputs_due.size() == 0) begin
            report_mismatch("response with nothing due, status", int'(rsp_status), -1);
         end else begin
            want = scaled_outputs_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_out_blue !== want.pixel.blue)
               report_mismatch("out_blue", int'(rsp_out_blue), int'(want.pixel.blue));
            if (rsp_out_green !== want.pixel.green)
               report_mismatch("out_green", int'(rsp_out_green), int'(want.pixel.green));
            if (rsp_out_red !== want.pixel.red)
               report_mismatch("out_red", int'(rsp_out_red), int'(want.pixel.red));
            if (rsp_line_end !== want.line_end)
               report_mismatch("line_end", int'(rsp_line_end), int'(want.line_end));
            if (rsp_pad_bytes !== want.pad_bytes)
               report_mismatch("pad_bytes", int'(rsp_pad_bytes), int'(want.pad_bytes));
            if (rsp_image_end !== want.image_end)
               report_mismatch("image_end", int'(rsp_image_end), int'(want.image_end));
         end
         responses_checked++;
         @(negedge clock);
      end
   end

   // Stimulus: reset, the directed table, then random phases.
   initial begin
      directed_step_type     steps [$];
      logic [CSR_DATA_W-1:0] word;
      logic                  kind;
      pixel_type             px;
      bit                    width_safe;
      int                    phase;
      int                    phase_len;
      int                    random_items;

      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = CSR_SCALE_FACTOR;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_type     = REQ_PUSH;
      req_in_blue  = '0;
      req_in_green = '0;
      req_in_red   = '0;
      phase        = 0;
      random_items = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset state: 1x1 image at factor 1. Tick before any push, the push that
      // fills the row, a refused push, the single output pixel (line end, one pad
      // byte, image end) and not ready once the row is spent.
      steps.push_back(typed_step(REQ_TICK, 24'hFFFFFF, STATUS_NOT_READY, 24'h0,
                                 1'b0, 2'd0, 1'b0));
      steps.push_back(typed_step(REQ_PUSH, 24'hFF00FF, STATUS_ACCEPTED, 24'h0,
                                 1'b0, 2'd0, 1'b0));
      steps.push_back(typed_step(REQ_PUSH, 24'h00FF00, STATUS_REFUSED, 24'h0,
                                 1'b0, 2'd0, 1'b0));
      steps.push_back(typed_step(REQ_TICK, 24'h000000, STATUS_PIXEL, 24'hFF00FF,
                                 1'b1, 2'd1, 1'b1));
      steps.push_back(typed_step(REQ_TICK, 24'h000000, STATUS_NOT_READY, 24'h0,
                                 1'b0, 2'd0, 1'b0));
      // 2x2 source at factor 2: one full source row, left mid-image
      steps.push_back(csr_step(CSR_SCALE_FACTOR, 13'd2));
      steps.push_back(csr_step(CSR_SOURCE_WIDTH, 13'd2));
      steps.push_back(csr_step(CSR_SOURCE_HEIGHT, 13'd2));
      steps.push_back(item_step(REQ_PUSH, 24'h000000));
      steps.push_back(item_step(REQ_PUSH, 24'hFFFFFF));
      repeat (8) steps.push_back(item_step(REQ_TICK, 24'h000000));
      // zero in every register acts as one; the row counter is past the new
      // height, so the next row closes the image
      steps.push_back(csr_step(CSR_SCALE_FACTOR, 13'd0));
      steps.push_back(csr_step(CSR_SOURCE_WIDTH, 13'd0));
      steps.push_back(csr_step(CSR_SOURCE_HEIGHT, 13'd0));
      steps.push_back(item_step(REQ_PUSH, 24'h563412));
      steps.push_back(item_step(REQ_TICK, 24'h000000));
      // all ones: factor, width and height clamp to their ceilings
      steps.push_back(csr_step(CSR_SCALE_FACTOR, 13'h1FFF));
      steps.push_back(csr_step(CSR_SOURCE_WIDTH, 13'h1FFF));
      steps.push_back(csr_step(CSR_SOURCE_HEIGHT, 13'h1FFF));
      steps.push_back(csr_step(CSR_SPARE_INDEX, 13'h1FFF));
      steps.push_back(item_step(REQ_PUSH, 24'hC35AA5));
      steps.push_back(item_step(REQ_TICK, 24'h000000));
      // lower the width mid-row so the next push completes it, then repeat at
      // factor 100 and drop the factor under the running repeat count
      steps.push_back(csr_step(CSR_SOURCE_WIDTH, 13'd1));
      steps.push_back(item_step(REQ_PUSH, 24'h3CC33C));
      repeat (3) steps.push_back(item_step(REQ_TICK, 24'h000000));
      steps.push_back(csr_step(CSR_SCALE_FACTOR, 13'd1));
      repeat (2) steps.push_back(item_step(REQ_TICK, 24'h000000));

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            drain(SETTLE_CYCLES);
            write_register(steps[i].csr_idx, steps[i].csr_data);
         end else begin
            send_item(steps[i].kind, steps[i].px, steps[i].typed, steps[i].want);
         end
      end

      // Random phases. Each one starts on an idle block, may rewrite any
      // register (small images most of the time, extremes now and then), and
      // then runs mostly well-formed traffic: pushes while the row fills, ticks
      // while it is held, with some misplaced requests as noise.
      while (random_items < RANDOM_ITEMS) begin
         drain(SETTLE_CYCLES);
         phase++;

         if ($urandom_range(0, 2) != 0) begin
            word = 13'($urandom);
            case ($urandom_range(0, 9))
               0:       word[6:0] = 7'd0;
               1:       word[6:0] = MAX_FACTOR;
               2:       word[6:0] = 7'($urandom_range(101, 127));
               3:       word[6:0] = 7'($urandom_range(4, 99));
               default: word[6:0] = 7'($urandom_range(1, 3));
            endcase
            write_register(CSR_SCALE_FACTOR, word);
         end

         if ($urandom_range(0, 2) != 0) begin
            word = 13'($urandom);
            case ($urandom_range(0, 9))
               0:       word[10:0] = 11'd0;
               1:       word[10:0] = 11'(MAX_W);
               2:       word[10:0] = 11'($urandom_range(MAX_W + 1, 2047));
               3:       word[10:0] = 11'($urandom_range(7, MAX_W - 1));
               default: word[10:0] = 11'($urandom_range(1, 6));
            endcase
            // Never widen a held row past the entries written so far.
            width_safe = 1'b1;
            if (row_held)
               for (int j = 0; j < effective_width(word[10:0]); j++)
                  if (!row_written[ROW_IDX_W'(j)]) width_safe = 1'b0;
            if (width_safe) write_register(CSR_SOURCE_WIDTH, word);
         end

         if ($urandom_range(0, 2) != 0) begin
            word = 13'($urandom);
            case ($urandom_range(0, 9))
               0:       word = 13'd0;
               1:       word = MAX_HEIGHT;
               2:       word = 13'($urandom_range(32'(MAX_HEIGHT) + 1, 8191));
               3:       word = 13'($urandom_range(4, 32'(MAX_HEIGHT) - 1));
               default: word = 13'($urandom_range(1, 3));
            endcase
            write_register(CSR_SOURCE_HEIGHT, word);
         end

         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) begin
            // freeze the response side while requests stream back to back
            tx_idle_on       = 1'b0;
            hold_off_request = 1'b1;
         end

         phase_len = int'($urandom_range(20, 90));
         for (int k = 0; k < phase_len; k++) begin
            // halfway through one phase, stop offering until all is answered
            if (phase == PAUSE_PHASE && k == phase_len / 2) drain(0);
            if ($urandom_range(0, 99) < 85)
               kind = row_held ? REQ_TICK : REQ_PUSH;
            else
               kind = row_held ? REQ_PUSH : REQ_TICK;
            px = 24'($urandom);
            send_item(kind, px, 1'b0, '0);
            random_items++;
         end
      end

      drain(SETTLE_CYCLES);
      $display("covered %0d request transfers in %0d random phases, %0d register writes",
               responses_checked, phase, csr_writes);
      $display("pixels %0d, line ends %0d, image ends %0d, accepted %0d, refused %0d, not ready %0d",
               status_count[STATUS_PIXEL], line_end_count, image_end_count,
               status_count[STATUS_ACCEPTED], status_count[STATUS_REFUSED],
               status_count[STATUS_NOT_READY]);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/pru_pkg.sv
hdl/pru_row_mem.sv
hdl/pru_ctrl.sv
hdl/pru_out_fifo.sv
hdl/pixel_replicate_upscaler.sv
tb/testbench.sv
